[hw/rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, codes and types for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int POINT_W  = 14;
	localparam int COLOR_W  = 24;
	localparam int STEP_W   = 12;
	localparam int ERR_W    = 14;
	localparam int RADIUS_W = 11;
	localparam int CALC_W   = 18;
	localparam int PHASE_W  = 3;

	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FFFF;

	localparam logic REG_COLOR_A = 1'b0;
	localparam logic REG_COLOR_B = 1'b1;

	localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [POINT_W-1:0] point_y;
		logic [POINT_W-1:0] point_x;
	} point_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

[hw/rtl/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front
// Accepts items, holds circle state and runs the midpoint step update.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   new_circle,
	input  logic [COORD_WIDTH-1:0] center_x,
	input  logic [COORD_WIDTH-1:0] center_y,
	input  logic [RADIUS_W-1:0]    radius,
	output logic                   push,
	output logic [COORD_WIDTH-1:0] rec_cx,
	output logic [COORD_WIDTH-1:0] rec_cy,
	output logic [STEP_W-1:0]      rec_x,
	output logic [STEP_W-1:0]      rec_y,
	output logic                   rec_done
);

	logic [COORD_WIDTH-1:0] center_col_q, center_row_q;
	logic [STEP_W-1:0]      step_x_q, step_y_q;
	logic [ERR_W-1:0]       err_q;
	logic                   active_q;

	logic [STEP_W-1:0]      x_cur, y_cur;
	logic [ERR_W-1:0]       e_cur;
	logic                   act, emit;
	logic signed [CALC_W-1:0] xs, ys, e0, y1, e1, x1, e2;
	logic                   le0, gt1, done;

	always_comb begin
		x_cur = new_circle ? STEP_W'(radius) : step_x_q;
		y_cur = new_circle ? '0 : step_y_q;
		e_cur = new_circle ? '0 : err_q;
		act   = new_circle | active_q;
		emit  = act && (x_cur >= y_cur);

		xs  = signed'(CALC_W'(x_cur));
		ys  = signed'(CALC_W'(y_cur));
		e0  = CALC_W'(signed'(e_cur));
		le0 = (e0 <= 0);
		y1  = le0 ? ys + 1 : ys;
		e1  = le0 ? e0 + (y1 <<< 1) + 1 : e0;
		gt1 = (e1 > 0);
		x1  = gt1 ? xs - 1 : xs;
		e2  = gt1 ? e1 - ((x1 <<< 1) + 1) : e1;
		done = (x1 < y1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (accept) begin
			if (new_circle) begin
				center_col_q <= center_x;
				center_row_q <= center_y;
			end
			if (act) begin
				if (emit) begin
					step_x_q <= x1[STEP_W-1:0];
					step_y_q <= y1[STEP_W-1:0];
					err_q    <= e2[ERR_W-1:0];
					active_q <= !done;
				end else begin
					step_x_q <= x_cur;
					step_y_q <= y_cur;
					err_q    <= e_cur;
					active_q <= 1'b0;
				end
			end
		end
	end

	assign push     = accept && emit;
	assign rec_cx   = new_circle ? center_x : center_col_q;
	assign rec_cy   = new_circle ? center_y : center_row_q;
	assign rec_x    = x_cur;
	assign rec_y    = y_cur;
	assign rec_done = done;

endmodule

[hw/rtl/mcr_fifo.sv]
// ----------------------------------------------------------------------------
// mcr_fifo
// Short queue of step records between front and back.
// ----------------------------------------------------------------------------
module mcr_fifo import mcr_pkg::*; #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output queue_status_t    status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back
// Point sequencer: expands one step record into eight points, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  queue_status_t          status,
	output logic                   pop,
	input  logic [COORD_WIDTH-1:0] rec_cx,
	input  logic [COORD_WIDTH-1:0] rec_cy,
	input  logic [STEP_W-1:0]      rec_x,
	input  logic [STEP_W-1:0]      rec_y,
	input  logic                   rec_done,
	input  logic [COLOR_W-1:0]     color_a,
	input  logic [COLOR_W-1:0]     color_b,
	output logic                   out_valid,
	input  logic                   out_ready,
	output point_t                 out_point,
	output logic                   out_last,
	output logic                   out_done
);

	localparam int SUM_W = ((COORD_WIDTH > POINT_W) ? COORD_WIDTH : POINT_W) + 1;

	logic [COORD_WIDTH-1:0] cx_q, cy_q;
	logic [STEP_W-1:0]      x_q, y_q;
	logic                   done_q, cur_valid_q;
	logic [PHASE_W-1:0]     phase_q;

	logic                   out_valid_q, out_last_q, out_done_q;
	point_t                 point_q;

	logic                   adv, finish;
	logic                   use_x_for_col, col_minus, row_minus;
	logic [SUM_W-1:0]       cx_e, cy_e, col_off, row_off, col_sum, row_sum;
	point_t                 point_next;

	assign adv    = cur_valid_q && (!out_valid_q || out_ready);
	assign finish = adv && (phase_q == PHASE_LAST);
	assign pop    = (!cur_valid_q || finish) && !status.empty;

	always_comb begin
		use_x_for_col = (phase_q == 3'd0) || (phase_q == 3'd3) ||
		                (phase_q == 3'd4) || (phase_q == 3'd7);
		col_minus     = (phase_q >= 3'd2) && (phase_q <= 3'd5);
		row_minus     = phase_q[2];
		cx_e    = SUM_W'(cx_q);
		cy_e    = SUM_W'(cy_q);
		col_off = use_x_for_col ? SUM_W'(x_q) : SUM_W'(y_q);
		row_off = use_x_for_col ? SUM_W'(y_q) : SUM_W'(x_q);
		col_sum = col_minus ? cx_e - col_off : cx_e + col_off;
		row_sum = row_minus ? cy_e - row_off : cy_e + row_off;
		point_next.point_x = col_sum[POINT_W-1:0];
		point_next.point_y = row_sum[POINT_W-1:0];
		point_next.color   = phase_q[0] ? color_a : color_b;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q   <= rec_cx;
			cy_q   <= rec_cy;
			x_q    <= rec_x;
			y_q    <= rec_y;
			done_q <= rec_done;
		end
		if (adv) begin
			point_q    <= point_next;
			out_last_q <= (phase_q == PHASE_LAST);
			out_done_q <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				phase_q     <= '0;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
				phase_q     <= '0;
			end else if (adv) begin
				phase_q <= phase_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_point = point_q;
	assign out_last  = out_last_q;
	assign out_done  = out_done_q;

endmodule

[hw/rtl/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle stepper streaming eight symmetric points per step.
// ----------------------------------------------------------------------------
// Each input transaction runs one step of a circle; a step that draws emits
// eight points from the point sequencer in the back end, one per clock
// while the output is not stalled. The front end updates the step state in
// the cycle a transaction is taken and parks the step in a two-entry queue,
// so up to two steps plus the one being drawn can be in flight; a
// transaction that draws nothing is not queued. From acceptance, the first
// point passes through the queue, the record registers and the output register.
module midpoint_circle_rasterizer import mcr_pkg::*; #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [COLOR_W-1:0]  cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// new_circle, center_x, center_y, radius, zero fill
	input  logic [((1 + 2 * COORD_WIDTH + RADIUS_W + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// point_x, point_y, point_color, zero fill
	output logic [55:0]         m_tdata,
	output logic                m_tlast,
	// circle_done
	output logic                m_tuser
);

	localparam int REC_W = 2 * COORD_WIDTH + 2 * STEP_W + 1;

	logic [COLOR_W-1:0]     color_a_q, color_b_q;
	logic                   accept, push, pop;
	logic [COORD_WIDTH-1:0] in_cx, in_cy, f_cx, f_cy, b_cx, b_cy;
	logic [RADIUS_W-1:0]    in_radius;
	logic [STEP_W-1:0]      f_x, f_y, b_x, b_y;
	logic                   f_done, b_done;
	logic [REC_W-1:0]       wr_rec, rd_rec;
	queue_status_t          q_status;
	point_t                 point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_a_q <= COLOR_RESET;
			color_b_q <= COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COLOR_A: color_a_q <= cfg_wdata;
				REG_COLOR_B: color_b_q <= cfg_wdata;
				default:     color_a_q <= color_a_q;
			endcase
		end
	end

	assign s_tready  = !q_status.full;
	assign accept    = s_tvalid && s_tready;
	assign in_cx     = s_tdata[COORD_WIDTH:1];
	assign in_cy     = s_tdata[2 * COORD_WIDTH:COORD_WIDTH + 1];
	assign in_radius = s_tdata[2 * COORD_WIDTH + RADIUS_W:2 * COORD_WIDTH + 1];

	mcr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.new_circle (s_tdata[0]),
		.center_x   (in_cx),
		.center_y   (in_cy),
		.radius     (in_radius),
		.push       (push),
		.rec_cx     (f_cx),
		.rec_cy     (f_cy),
		.rec_x      (f_x),
		.rec_y      (f_y),
		.rec_done   (f_done)
	);

	assign wr_rec = {f_done, f_y, f_x, f_cy, f_cx};
	assign {b_done, b_y, b_x, b_cy, b_cx} = rd_rec;

	mcr_fifo #(.WIDTH(REC_W), .DEPTH(2)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_rec),
		.pop     (pop),
		.rd_data (rd_rec),
		.status  (q_status)
	);

	mcr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (q_status),
		.pop       (pop),
		.rec_cx    (b_cx),
		.rec_cy    (b_cy),
		.rec_x     (b_x),
		.rec_y     (b_y),
		.rec_done  (b_done),
		.color_a   (color_a_q),
		.color_b   (color_b_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_point (point),
		.out_last  (m_tlast),
		.out_done  (m_tuser)
	);

	assign m_tdata = {4'b0000, point};

endmodule

[sim/circle_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_checker
// Watches the input, output and register channels of the midpoint circle
// rasterizer, computes the points every accepted step should draw and
// compares each output transaction against the oldest pending point.
// ----------------------------------------------------------------------------
module circle_checker import mcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [COLOR_W-1:0] cfg_wdata,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [39:0]        s_tdata,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [55:0]        m_tdata,
	input  logic               m_tlast,
	input  logic               m_tuser,
	output int                 mismatches,
	output int                 points_pending
);

	typedef struct {
		logic signed [POINT_W-1:0] px;
		logic signed [POINT_W-1:0] py;
		logic [COLOR_W-1:0]        color;
		logic                      last_of_step;
		logic                      circle_done;
	} circle_point_t;

	circle_point_t pending_points[$];

	logic [COLOR_W-1:0]      color_odd;
	logic [COLOR_W-1:0]      color_even;
	logic [11:0]             ctr_x;
	logic [11:0]             ctr_y;
	logic [STEP_W-1:0]       run_x;
	logic [STEP_W-1:0]       run_y;
	logic signed [ERR_W-1:0] run_err;
	logic                    drawing;

	initial mismatches = 0;
	initial points_pending = 0;

	task automatic report(input string field, input longint exp, input longint act);
		mismatches++;
		$display("%0t: %s expected %0d actual %0d", $time, field, exp, act);
	endtask

	// one step of the midpoint circle for an accepted item
	task automatic draw_step(input logic [39:0] item);
		int cx, cy, x, y, err;
		int px[8];
		int py[8];
		logic finished;
		circle_point_t pt;
		if (item[0]) begin
			ctr_x   = item[12:1];
			ctr_y   = item[24:13];
			run_x   = {1'b0, item[35:25]};
			run_y   = '0;
			run_err = '0;
			drawing = 1'b1;
		end
		if (!drawing)
			return;
		cx  = int'(ctr_x);
		cy  = int'(ctr_y);
		x   = int'(run_x);
		y   = int'(run_y);
		err = int'(run_err);
		if (x < y) begin
			drawing = 1'b0;
			return;
		end
		px[0] = cx + x; py[0] = cy + y;
		px[1] = cx + y; py[1] = cy + x;
		px[2] = cx - y; py[2] = cy + x;
		px[3] = cx - x; py[3] = cy + y;
		px[4] = cx - x; py[4] = cy - y;
		px[5] = cx - y; py[5] = cy - x;
		px[6] = cx + y; py[6] = cy - x;
		px[7] = cx + x; py[7] = cy - y;
		if (err <= 0) begin
			y   = y + 1;
			err = err + 2 * y + 1;
		end
		if (err > 0) begin
			x   = x - 1;
			err = err - (2 * x + 1);
		end
		finished = (x < y);
		run_x    = STEP_W'(x);
		run_y    = STEP_W'(y);
		run_err  = ERR_W'(err);
		if (finished)
			drawing = 1'b0;
		for (int k = 0; k < 8; k++) begin
			pt.px           = POINT_W'(px[k]);
			pt.py           = POINT_W'(py[k]);
			pt.color        = k[0] ? color_odd : color_even;
			pt.last_of_step = (k == 7);
			pt.circle_done  = finished;
			pending_points.push_back(pt);
		end
	endtask

	task automatic check_point();
		circle_point_t exp;
		logic signed [POINT_W-1:0] act_x;
		logic signed [POINT_W-1:0] act_y;
		act_x = m_tdata[13:0];
		act_y = m_tdata[27:14];
		if (pending_points.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected point, expected none actual x %0d y %0d", $time,
				act_x, act_y);
			return;
		end
		exp = pending_points.pop_front();
		if (act_x !== exp.px)
			report("point_x", exp.px, act_x);
		if (act_y !== exp.py)
			report("point_y", exp.py, act_y);
		if (m_tdata[51:28] !== exp.color)
			report("point_color", exp.color, m_tdata[51:28]);
		if (m_tlast !== exp.last_of_step)
			report("last_of_step", exp.last_of_step, m_tlast);
		if (m_tuser !== exp.circle_done)
			report("circle_done", exp.circle_done, m_tuser);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_odd  = COLOR_RESET;
			color_even = COLOR_RESET;
			ctr_x      = '0;
			ctr_y      = '0;
			run_x      = '0;
			run_y      = '0;
			run_err    = '0;
			drawing    = 1'b0;
			pending_points.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_point();
			if (cfg_we) begin
				if (cfg_addr == REG_COLOR_A)
					color_odd = cfg_wdata;
				else
					color_even = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				draw_step(s_tdata);
		end
		points_pending = pending_points.size();
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives circle steps into the midpoint circle rasterizer with random gaps
// and output stalls across several color settings; the checker beside the
// block predicts every point and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module testbench import mcr_pkg::*;;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD    = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_addr = REG_COLOR_A;
	logic [COLOR_W-1:0] cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// new_circle, center_x, center_y, radius, zero fill
	logic [39:0]        s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// point_x, point_y, point_color, zero fill
	logic [55:0]        m_tdata;
	logic               m_tlast;
	// circle_done
	logic               m_tuser;

	int   mismatches;
	int   points_pending;
	int   cycles = 0;
	logic sender_fast = 1'b0;
	logic long_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midpoint_circle_rasterizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	circle_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.points_pending(points_pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output side: random stalls, no-stall bursts, one long hold on request
	initial begin
		int gap;
		int burst_left;
		burst_left = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD;
			end else if (burst_left > 0) begin
				burst_left--;
				gap = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				burst_left = $urandom_range(20, 120);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 18);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_item(input logic start, input logic [11:0] cx, input logic [11:0] cy,
		input logic [RADIUS_W-1:0] r);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {4'b0, r, cy, cx, start};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// continuation steps; the center and radius bits are don't-care
	task automatic send_steps(input int n);
		repeat (n)
			send_item(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
				RADIUS_W'($urandom_range(0, 2047)));
	endtask

	task automatic write_color(input logic addr, input logic [COLOR_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (points_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int items);
		int sent, radius, steps, span;
		sent = 0;
		while (sent < items) begin
			sender_fast = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				send_steps($urandom_range(1, 3));
			radius = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(0, 24);
			steps = radius * 181 / 256 + 1;
			span = (steps > 40) ? $urandom_range(0, 40) : $urandom_range(0, steps + 1);
			send_item(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
				RADIUS_W'(radius));
			send_steps(span);
			sent += 1 + span;
		end
		sender_fast = 1'b0;
	endtask

	task automatic run_phase(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b,
		input int items);
		drain();
		write_color(REG_COLOR_A, a);
		write_color(REG_COLOR_B, b);
		run_random(items);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset, zero radius, idle after the final step
		send_item(1'b0, 12'd5, 12'd5, 11'd5);
		send_item(1'b1, 12'd0, 12'd0, 11'd0);
		send_item(1'b0, 12'hFFF, 12'hFFF, 11'h7FF);
		// largest radius at the far corner, then restarts mid-circle
		send_item(1'b1, 12'hFFF, 12'hFFF, 11'h7FF);
		send_steps(2);
		send_item(1'b1, 12'd0, 12'd0, 11'h7FF);
		send_steps(1);
		send_item(1'b1, 12'hFFF, 12'd0, 11'd1);
		send_steps(2);
		send_item(1'b1, 12'd0, 12'hFFF, 11'd3);
		send_steps(3);
		// long output hold while steps keep coming back to back
		drain();
		long_hold_req = 1'b1;
		sender_fast = 1'b1;
		send_item(1'b1, 12'd2048, 12'd2048, 11'h7FF);
		send_steps(12);
		sender_fast = 1'b0;
		run_random(100);

		run_phase(24'h000000, 24'h000000, 100);
		run_phase(24'hFFFFFF, 24'h000000, 100);
		run_phase(24'h000000, 24'hFFFFFF, 100);
		run_phase(COLOR_W'($urandom_range(0, 24'hFFFFFF)),
			COLOR_W'($urandom_range(0, 24'hFFFFFF)), 100);
		drain();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
